@@ design/aonb_pkg.sv @@
// shared types and constants for the all-or-nothing block claim
// no dependencies; imported by every module of the block but the RAM

package aonb_pkg;

  localparam int NUM_BLOCKS         = 128;
  localparam int MAX_REQUEST_BLOCKS = 32;
  localparam int NUM_FILES          = 16;

  localparam int BLK_W   = $clog2(NUM_BLOCKS);
  localparam int FILE_W  = $clog2(NUM_FILES);
  localparam int TOTAL_W = 8;
  localparam int PEND_AW = (MAX_REQUEST_BLOCKS > 1) ? $clog2(MAX_REQUEST_BLOCKS) : 1;
  localparam int CNT_W   = $clog2(MAX_REQUEST_BLOCKS + 1);

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(128);

  typedef enum logic [1:0] {
    VERDICT_GRANTED  = 2'd0,
    VERDICT_IN_USE   = 2'd1,
    VERDICT_RANGE    = 2'd2,
    VERDICT_TOO_LONG = 2'd3
  } verdict_e;

  // one finished request handed from front to back
  typedef struct packed {
    logic [FILE_W-1:0] file;
    verdict_e          verdict;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  // pending buffer write port
  typedef struct packed {
    logic               en;
    logic [PEND_AW-1:0] addr;
    logic [BLK_W-1:0]   data;
  } pend_wr_t;

  // pending buffer read port
  typedef struct packed {
    logic               en;
    logic [PEND_AW-1:0] addr;
  } pend_rd_t;

  // mark one block as owned
  typedef struct packed {
    logic             valid;
    logic [BLK_W-1:0] idx;
  } set_t;

endpackage

@@ design/aonb_ram.sv @@
// generic single write, single read RAM with registered read data
// no dependencies

module aonb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/aonb_fifo.sv @@
// two-entry command queue between the front and the back
// depends on aonb_pkg

module aonb_fifo import aonb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ design/aonb_front.sv @@
// front: accepts request items, checks each block, buffers it, closes requests
// depends on aonb_pkg; holds the block ownership bitmap

module aonb_front import aonb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FILE_W-1:0]  file_number_i,
  input  logic [BLK_W-1:0]   block_number_i,
  input  logic               has_block_i,
  input  logic               last_of_request_i,
  input  logic [TOTAL_W-1:0] total_blocks_i,
  input  logic               back_busy_i,
  input  logic               cmd_full_i,
  input  set_t               set_i,
  output pend_wr_t           pend_wr_o,
  output logic               cmd_push_o,
  output cmd_t               cmd_o
);

  logic [NUM_BLOCKS-1:0] used_q;
  logic [CNT_W-1:0]      count_q, count_item;
  verdict_e              fault_q, fault_item;
  logic                  accept, take, out_of_range;

  assign in_stall_o = back_busy_i | cmd_full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign out_of_range =
      ({{(TOTAL_W){1'b0}}, block_number_i} >= {{(BLK_W){1'b0}}, total_blocks_i}) ||
      ({1'b0, block_number_i} >= (BLK_W+1)'(NUM_BLOCKS));

  // range first, then length, then ownership
  always_comb begin
    fault_item = fault_q;
    take       = 1'b0;
    if (has_block_i && (fault_q == VERDICT_GRANTED)) begin
      if (out_of_range) begin
        fault_item = VERDICT_RANGE;
      end else if (count_q >= CNT_W'(MAX_REQUEST_BLOCKS)) begin
        fault_item = VERDICT_TOO_LONG;
      end else if (used_q[block_number_i]) begin
        fault_item = VERDICT_IN_USE;
      end else begin
        take = 1'b1;
      end
    end
    count_item = count_q + CNT_W'(take);
  end

  always_comb begin
    pend_wr_o.en   = accept & take;
    pend_wr_o.addr = count_q[PEND_AW-1:0];
    pend_wr_o.data = block_number_i;
    cmd_push_o     = accept & last_of_request_i;
    cmd_o.file     = file_number_i;
    cmd_o.verdict  = fault_item;
    cmd_o.count    = count_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      fault_q <= VERDICT_GRANTED;
    end else if (accept) begin
      if (last_of_request_i) begin
        count_q <= '0;
        fault_q <= VERDICT_GRANTED;
      end else begin
        count_q <= count_item;
        fault_q <= fault_item;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (set_i.valid) begin
      used_q[set_i.idx] <= 1'b1;
    end
  end

endmodule

@@ design/aonb_back.sv @@
// back: takes closed requests, commits granted blocks, presents the verdict
// depends on aonb_pkg

module aonb_back import aonb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_empty_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  output pend_rd_t          pend_rd_o,
  input  logic [BLK_W-1:0]  pend_rdata_i,
  output set_t              set_o,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [FILE_W-1:0] granted_file_o,
  output logic [1:0]        verdict_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_HOLD  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              rd_v_q;
  cmd_t              cur_q, cur_d;
  logic              out_valid_q, out_valid_d;
  logic [FILE_W-1:0] out_file_q, out_file_d;
  logic [1:0]        out_verdict_q, out_verdict_d;
  logic              out_free;

  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign cmd_pop_o = (state_q == S_IDLE) & ~cmd_empty_i;
  assign busy_o    = ~cmd_empty_i | (state_q == S_SWEEP) | (state_q == S_FLUSH);

  assign pend_rd_o.en   = (state_q == S_SWEEP);
  assign pend_rd_o.addr = idx_q[PEND_AW-1:0];
  // read data is registered and lands in the cycle after its address
  assign set_o.valid    = rd_v_q;
  assign set_o.idx      = pend_rdata_i;

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cur_d         = cur_q;
    out_valid_d   = out_valid_q & out_stall_i;
    out_file_d    = out_file_q;
    out_verdict_d = out_verdict_q;
    case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cur_d = cmd_i;
          idx_d = '0;
          if ((cmd_i.verdict == VERDICT_GRANTED) && (cmd_i.count != '0)) begin
            state_d = S_SWEEP;
          end else begin
            state_d = S_HOLD;
          end
        end
      end
      S_SWEEP: begin
        idx_d = idx_q + CNT_W'(1);
        if (idx_d == cur_q.count) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_d = S_HOLD;
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_file_d    = cur_q.file;
          out_verdict_d = cur_q.verdict;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q         <= cur_d;
    idx_q         <= idx_d;
    out_file_q    <= out_file_d;
    out_verdict_q <= out_verdict_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_v_q      <= (state_q == S_SWEEP);
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_file_o = out_file_q;
  assign verdict_o      = out_verdict_q;

endmodule

@@ design/all_or_nothing_block_claim.sv @@
// top level of the all-or-nothing block claim
// depends on aonb_pkg, aonb_front, aonb_fifo, aonb_back, aonb_ram
//
// usage
// - input channel (in_valid_i / in_stall_o): one transaction per block of a
//   request; has_block_i low adds no block, last_of_request_i closes the request
// - output channel (out_valid_o / out_stall_i): one transaction per closed
//   request carrying the file number of the final item and the verdict
//   (granted, block in use, out of range, request too long)
// - cfg_we_i / cfg_wdata_i set total_blocks, reset value 128; write while idle
// - each block item is checked in the front against the ownership bitmap
//   and stored in a 32-entry pending RAM
// - a granted request of N blocks is committed by the back reading the
//   pending RAM one entry per cycle, then a flush step for the last write;
//   an empty or refused request skips both, then the verdict is registered
// - the commit does not overlap the input: items of the next request are
//   held off until the commit writes are done
// - the output register frees the back from a stalled receiver: the next
//   request can be taken while a verdict still waits
// - reset marks every block free and clears any open request

module all_or_nothing_block_claim import aonb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FILE_W-1:0]  file_number_i,
  input  logic [BLK_W-1:0]   block_number_i,
  input  logic               has_block_i,
  input  logic               last_of_request_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FILE_W-1:0]  granted_file_o,
  output logic [1:0]         verdict_o,
  input  logic               cfg_we_i,
  input  logic [TOTAL_W-1:0] cfg_wdata_i
);

  logic [TOTAL_W-1:0] total_blocks_q;
  pend_wr_t           pend_wr;
  pend_rd_t           pend_rd;
  logic [BLK_W-1:0]   pend_rdata;
  set_t               set;
  cmd_t               cmd_in, cmd_out;
  logic               cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic               back_busy;

  // total_blocks config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_blocks_q <= TOTAL_RESET;
    end else if (cfg_we_i) begin
      total_blocks_q <= cfg_wdata_i;
    end
  end

  // front: check and buffer each block
  aonb_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .file_number_i     (file_number_i),
    .block_number_i    (block_number_i),
    .has_block_i       (has_block_i),
    .last_of_request_i (last_of_request_i),
    .total_blocks_i    (total_blocks_q),
    .back_busy_i       (back_busy),
    .cmd_full_i        (cmd_full),
    .set_i             (set),
    .pend_wr_o         (pend_wr),
    .cmd_push_o        (cmd_push),
    .cmd_o             (cmd_in)
  );

  // pending block buffer of the open request
  aonb_ram #(
    .WIDTH (BLK_W),
    .DEPTH (MAX_REQUEST_BLOCKS)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_wr.en),
    .waddr_i (pend_wr.addr),
    .wdata_i (pend_wr.data),
    .re_i    (pend_rd.en),
    .raddr_i (pend_rd.addr),
    .rdata_o (pend_rdata)
  );

  // closed requests waiting for the back
  aonb_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  // back: commit and report
  aonb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_empty_i    (cmd_empty),
    .cmd_i          (cmd_out),
    .cmd_pop_o      (cmd_pop),
    .pend_rd_o      (pend_rd),
    .pend_rdata_i   (pend_rdata),
    .set_o          (set),
    .busy_o         (back_busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_file_o (granted_file_o),
    .verdict_o      (verdict_o)
  );

`ifndef SYNTH
  // a request is only closed while no earlier one is still queued
  a_push_into_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> cmd_empty)
    else $error("request closed while another is still queued");

  // commit writes never overlap an accepted block
  a_no_accept_in_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set.valid |-> !(in_valid_i && !in_stall_o))
    else $error("item accepted during commit");

  // pending buffer is never read and written in the same cycle
  a_pend_ports_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_rd.en |-> !pend_wr.en)
    else $error("pending buffer read and written together");
`endif

endmodule

@@ bench/claim_verdict_checker.sv @@
// checker for the all-or-nothing block claim: watches both channels and the total_blocks port
// predicts each verdict from its own copy of the owner table; depends on aonb_pkg
`timescale 1ns / 1ps

module claim_verdict_checker import aonb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [FILE_W-1:0]  file_number_i,
  input  logic [BLK_W-1:0]   block_number_i,
  input  logic               has_block_i,
  input  logic               last_of_request_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [FILE_W-1:0]  granted_file_i,
  input  logic [1:0]         verdict_i,
  input  logic               cfg_we_i,
  input  logic [TOTAL_W-1:0] cfg_wdata_i,
  output int unsigned        fail_count_o,
  output int unsigned        open_verdicts_o
);

  localparam logic [4:0] OWNER_FREE = 5'd31;

  typedef struct packed {
    logic [FILE_W-1:0] file;
    verdict_e          verdict;
  } claim_verdict_t;

  logic [4:0]         owner_map [NUM_BLOCKS];
  logic [BLK_W-1:0]   held_blocks [MAX_REQUEST_BLOCKS];
  int unsigned        held_count;
  verdict_e           first_fault;
  logic [TOTAL_W-1:0] block_limit;
  claim_verdict_t     verdict_q [$];
  int unsigned        fail_total;

  // range, then length, then ownership; nothing more once a fault is recorded
  function automatic void screen_block(input logic [BLK_W-1:0] blk);
    if (first_fault != VERDICT_GRANTED) return;
    if ({1'b0, blk} >= block_limit) begin
      first_fault = VERDICT_RANGE;
    end else if (held_count >= MAX_REQUEST_BLOCKS) begin
      first_fault = VERDICT_TOO_LONG;
    end else if (owner_map[blk] != OWNER_FREE) begin
      first_fault = VERDICT_IN_USE;
    end else begin
      held_blocks[held_count] = blk;
      held_count++;
    end
  endfunction

  function automatic void claim_item(input logic [FILE_W-1:0] fnum,
                                     input logic [BLK_W-1:0] blk,
                                     input logic has, input logic last);
    claim_verdict_t got;
    if (has) screen_block(blk);
    if (!last) return;
    // commit only when clean; owner is the file of the closing item
    if (first_fault == VERDICT_GRANTED) begin
      for (int i = 0; i < held_count; i++) owner_map[held_blocks[i]] = 5'(fnum % NUM_FILES);
    end
    got.file    = fnum;
    got.verdict = first_fault;
    verdict_q.push_back(got);
    held_count  = 0;
    first_fault = VERDICT_GRANTED;
  endfunction

  function automatic void compare_verdict();
    claim_verdict_t want;
    if (verdict_q.size() == 0) begin
      $error("verdict transaction with none expected: granted_file %0d verdict %0d",
             granted_file_i, verdict_i);
      fail_total++;
      return;
    end
    want = verdict_q.pop_front();
    if (granted_file_i !== want.file) begin
      $error("granted_file: expected %0d, got %0d", want.file, granted_file_i);
      fail_total++;
    end
    if (verdict_i !== want.verdict) begin
      $error("verdict: expected %0d, got %0d", want.verdict, verdict_i);
      fail_total++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BLOCKS; b++) owner_map[b] = OWNER_FREE;
      held_count  = 0;
      first_fault = VERDICT_GRANTED;
      block_limit = TOTAL_RESET;
      verdict_q.delete();
      fail_total  = 0;
      fail_count_o    <= 0;
      open_verdicts_o <= 0;
    end else begin
      if (cfg_we_i) block_limit = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) compare_verdict();
      if (in_valid_i && !in_stall_i) begin
        claim_item(file_number_i, block_number_i, has_block_i, last_of_request_i);
      end
      fail_count_o    <= fail_total;
      open_verdicts_o <= verdict_q.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
// top of the block claim bench: clock, reset, request stimulus and the final verdict
// depends on aonb_pkg, all_or_nothing_block_claim and claim_verdict_checker
`timescale 1ns / 1ps

module tb_top;
  import aonb_pkg::*;

  // room for the longest commit plus the output register
  localparam int SETTLE_CYCLES = MAX_REQUEST_BLOCKS + 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 100;

  localparam int SENDER_IDLE [4] = '{0, 63, 0, 13};
  localparam int RECV_STALL  [4] = '{0, 0, 63, 13};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [FILE_W-1:0]  file_number_i = '0;
  logic [BLK_W-1:0]   block_number_i = '0;
  logic               has_block_i = 1'b0;
  logic               last_of_request_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [FILE_W-1:0]  granted_file_o;
  logic [1:0]         verdict_o;
  logic               cfg_we_i = 1'b0;
  logic [TOTAL_W-1:0] cfg_wdata_i = '0;

  int unsigned fail_count;
  int unsigned open_verdicts;
  int unsigned cycle_count = 0;

  // idle and stall odds in percent, changed per phase
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int unsigned items_sent = 0;

  // blocks never named by the stimulus so far; feeds well-formed claims
  bit               block_used [NUM_BLOCKS];
  logic [BLK_W-1:0] fresh_blocks [$];

  all_or_nothing_block_claim dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .file_number_i     (file_number_i),
    .block_number_i    (block_number_i),
    .has_block_i       (has_block_i),
    .last_of_request_i (last_of_request_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .granted_file_o    (granted_file_o),
    .verdict_o         (verdict_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  claim_verdict_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .file_number_i     (file_number_i),
    .block_number_i    (block_number_i),
    .has_block_i       (has_block_i),
    .last_of_request_i (last_of_request_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .granted_file_i    (granted_file_o),
    .verdict_i         (verdict_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .fail_count_o      (fail_count),
    .open_verdicts_o   (open_verdicts)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog against a hung handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one input transaction: optional idle gap, then hold until taken
  task automatic send_claim_item(input logic [FILE_W-1:0] fnum, input logic [BLK_W-1:0] blk,
                                 input bit has, input bit last);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    file_number_i     <= fnum;
    block_number_i    <= blk;
    has_block_i       <= has;
    last_of_request_i <= last;
    if (has) block_used[blk] = 1'b1;
    if (has || last) items_sent++;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
  endtask

  // sender pauses until every verdict is back and the commit has drained
  task automatic settle_claims();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (open_verdicts != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // only called while the block is idle
  task automatic write_total_blocks(input logic [TOTAL_W-1:0] total);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= total;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly fresh blocks so grants keep happening, the rest anywhere
  function automatic logic [BLK_W-1:0] pick_block();
    if (fresh_blocks.size() != 0 && $urandom_range(0, 9) < 7) return fresh_blocks.pop_front();
    return BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
  endfunction

  // one random request: a run of blocks with noise file numbers and
  // stray empty items, closed either on a block or on an empty item
  task automatic issue_random_request();
    logic [FILE_W-1:0] owner;
    logic [BLK_W-1:0]  blk;
    bit                long_run;
    bit                close_empty;
    int                n;
    owner       = FILE_W'($urandom);
    long_run    = ($urandom_range(0, 19) == 0);
    n           = long_run ? $urandom_range(30, 34) : $urandom_range(0, 4);
    close_empty = (n == 0) || ($urandom_range(0, 4) == 0);
    blk         = pick_block();
    for (int i = 0; i < n; i++) begin
      // a long run repeats one block to probe the buffer limit
      if (!long_run && i != 0) blk = pick_block();
      if ($urandom_range(0, 7) == 0) send_claim_item(FILE_W'($urandom), BLK_W'($urandom), 0, 0);
      if (!close_empty && i == n - 1) send_claim_item(owner, blk, 1, 1);
      else send_claim_item(FILE_W'($urandom), blk, 1, 0);
    end
    if (close_empty) send_claim_item(owner, BLK_W'($urandom), 0, 1);
  endtask

  initial begin
    int               j;
    int               phase_goal;
    logic [BLK_W-1:0] swap_blk;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, total_blocks at its reset value of 128
    // empty request is granted and claims nothing
    send_claim_item(4'd0, 7'h55, 0, 1);
    // both ends of the block range
    send_claim_item(4'd15, 7'd0, 1, 0);
    send_claim_item(4'd15, 7'd127, 1, 1);
    send_claim_item(4'd3, 7'd0, 1, 1);
    // only the closing item's file counts, empty item in the middle
    send_claim_item(4'd1, 7'd5, 1, 0);
    send_claim_item(4'd9, 7'd99, 0, 0);
    send_claim_item(4'd2, 7'd6, 1, 1);
    // first fault wins: block 9 must stay free after the refusal
    send_claim_item(4'd4, 7'd6, 1, 0);
    send_claim_item(4'd4, 7'd9, 1, 1);
    send_claim_item(4'd5, 7'd9, 1, 1);
    // repeated block inside one request
    send_claim_item(4'd6, 7'd10, 1, 0);
    send_claim_item(4'd6, 7'd10, 1, 1);
    // one block past the buffer, then the same block claimed alone
    for (int i = 0; i < MAX_REQUEST_BLOCKS + 1; i++) begin
      send_claim_item(4'd7, 7'd20, 1, i == MAX_REQUEST_BLOCKS);
    end
    send_claim_item(4'd12, 7'd20, 1, 1);
    settle_claims();

    // total of one: only block 0 in range
    write_total_blocks(8'd1);
    send_claim_item(4'd7, 7'd0, 1, 1);
    send_claim_item(4'd7, 7'd1, 1, 1);
    send_claim_item(4'd8, 7'd1, 1, 0);
    send_claim_item(4'd8, 7'd0, 1, 1);
    settle_claims();

    // zero refuses every block but not an empty request
    write_total_blocks(8'd0);
    send_claim_item(4'd8, 7'd0, 1, 1);
    send_claim_item(4'd10, 7'd0, 0, 1);
    settle_claims();

    // total above the table size
    write_total_blocks(8'd255);
    send_claim_item(4'd11, 7'd127, 1, 1);
    send_claim_item(4'd11, 7'd126, 1, 1);
    settle_claims();

    // shuffle the blocks the directed part left untouched
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      if (!block_used[b]) fresh_blocks.push_back(BLK_W'(b));
    end
    for (int i = fresh_blocks.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap_blk        = fresh_blocks[i];
      fresh_blocks[i] = fresh_blocks[j];
      fresh_blocks[j] = swap_blk;
    end

    // random phases: no idling, sender idle, receiver stall, both
    phase_goal = items_sent;
    for (int p = 0; p < 4; p++) begin
      idle_pct  = SENDER_IDLE[p];
      stall_pct = RECV_STALL[p];
      case (p)
        0:       write_total_blocks(8'd128);
        1:       write_total_blocks(TOTAL_W'($urandom_range(2, 127)));
        2:       write_total_blocks(8'd255);
        default: write_total_blocks(TOTAL_W'($urandom_range(100, 128)));
      endcase
      phase_goal += PHASE_ITEMS;
      while (items_sent < phase_goal) issue_random_request();
      settle_claims();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/aonb_pkg.sv
design/aonb_ram.sv
design/aonb_fifo.sv
design/aonb_front.sv
design/aonb_back.sv
design/all_or_nothing_block_claim.sv
bench/claim_verdict_checker.sv
bench/tb_top.sv
